>>> rtl/sarb_pkg.sv
`timescale 1ns / 1ps
package sarb_pkg;

  localparam int SRC_DIM   = 256;
  localparam int SRC_AW    = 8;
  localparam int SRC_DEPTH = SRC_DIM * SRC_DIM;
  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int POS_W     = 10;
  localparam int ATL_W     = 11;
  localparam int SRC_W     = 9;
  localparam int CRD_W     = 12;
  localparam int OFS_W     = 10;
  localparam int PROD_W    = 20;
  localparam int REM_W     = 20;
  localparam int IDX_W     = SRC_AW;
  localparam int DIV_STG   = 4;
  localparam int SUM_W     = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  localparam logic [ATL_W-1:0] ATL_RST = ATL_W'(256);
  localparam logic [CH_W-1:0]  CH_MAX  = 8'd255;

  typedef enum logic [2:0] {
    REG_ATLAS_W  = 3'd0,
    REG_ATLAS_H  = 3'd1,
    REG_SRC_W    = 3'd2,
    REG_SRC_H    = 3'd3,
    REG_REGION_X = 3'd4,
    REG_REGION_Y = 3'd5,
    REG_REGION_W = 3'd6,
    REG_REGION_H = 3'd7
  } sarb_reg_t;

  typedef struct packed {
    logic                  vld;
    logic                  proc;
    logic                  cov;
    logic                  wr_ok;
    logic [2*SRC_AW-1:0]   waddr;
    logic [PIX_W-1:0]      pix;
  } sarb_ctl_t;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
    logic [SUM_W:0] t;
    t = (SUM_W+1)'(x) + (SUM_W+1)'(x[SUM_W-1:CH_W]) + (SUM_W+1)'(1);
    return t[SUM_W-1:CH_W];
  endfunction

endpackage

>>> rtl/scaled_alpha_region_blit.sv
// Alpha-blends a stored 256 by 256 RGBA source image onto a streamed atlas inside a
// region given in 256 by 256 reference space. Load words (tuser 0) write one source
// pixel into a 65536-word RAM; process words (tuser 1) return one blended atlas pixel
// each, with covered set when the pixel fell inside the scaled region. One word is
// taken in every cycle unless the pipeline holds, which it does while a result waits
// with out_tready low. The nearest-neighbor source index comes from a pipelined divider
// that retires two quotient bits per stage, and the RAM read sits in the same stage as
// the RAM write, so a process word always sees every load accepted before it. Registers
// may only be written while no word is in flight; they take effect for words accepted
// from the cycle after the write.
`timescale 1ns / 1ps
module scaled_alpha_region_blit (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: pos_x, pos_y, red, green, blue, alpha, zero padding.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sarb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type.
  input  logic                             in_tuser,
  // out_tdata: out_red, out_green, out_blue, out_alpha.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sarb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: covered.
  output logic                             out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sarb_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [sarb_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [sarb_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  import sarb_pkg::*;

  logic [ATL_W-1:0] atl_w_r, atl_h_r;
  logic [SRC_W-1:0] src_w_r, src_h_r, reg_x_r, reg_y_r, reg_w_r, reg_h_r;
  logic [CRD_W-1:0] x0_r, y0_r, dw_r, dh_r;
  logic [SRC_W-1:0] sw_r, sh_r;
  logic             src_ok_r;
  logic [PROD_W-1:0] px0_w, py0_w, pdw_w, pdh_w;
  logic              cfg_wr;
  sarb_reg_t         cfg_idx;

  logic adv;

  sarb_ctl_t        a_ctl_r, b_ctl_r, b_ctl_nxt, e_ctl_r, f_ctl_r;
  logic [POS_W-1:0] a_px_r, a_py_r;
  logic [OFS_W-1:0] b_offx_r, b_offy_r, b_offx_nxt, b_offy_nxt;

  sarb_ctl_t        dctl_r   [DIV_STG+1];
  sarb_ctl_t        dctl_nxt [DIV_STG+1];
  logic [REM_W-1:0] remx_r   [DIV_STG+1];
  logic [REM_W-1:0] remx_nxt [DIV_STG+1];
  logic [REM_W-1:0] remy_r   [DIV_STG+1];
  logic [REM_W-1:0] remy_nxt [DIV_STG+1];
  logic [IDX_W-1:0] qx_r     [DIV_STG+1];
  logic [IDX_W-1:0] qx_nxt   [DIV_STG+1];
  logic [IDX_W-1:0] qy_r     [DIV_STG+1];
  logic [IDX_W-1:0] qy_nxt   [DIV_STG+1];

  logic                ram_we, ram_re;
  logic [2*SRC_AW-1:0] ram_raddr;
  logic [PIX_W-1:0]    ram_rdata;

  logic [SUM_W-1:0] f_sum_r [3];
  logic [SUM_W-1:0] f_sum_nxt [3];
  logic [PIX_W-1:0] f_src_r;

  logic             out_vld_r, out_cov_r;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = sarb_reg_t'(cfg_paddr[CFG_AW-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_ATLAS_W:  cfg_prdata = CFG_DW'(atl_w_r);
      REG_ATLAS_H:  cfg_prdata = CFG_DW'(atl_h_r);
      REG_SRC_W:    cfg_prdata = CFG_DW'(src_w_r);
      REG_SRC_H:    cfg_prdata = CFG_DW'(src_h_r);
      REG_REGION_X: cfg_prdata = CFG_DW'(reg_x_r);
      REG_REGION_Y: cfg_prdata = CFG_DW'(reg_y_r);
      REG_REGION_W: cfg_prdata = CFG_DW'(reg_w_r);
      REG_REGION_H: cfg_prdata = CFG_DW'(reg_h_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atl_w_r <= ATL_RST;
      atl_h_r <= ATL_RST;
      src_w_r <= '0;
      src_h_r <= '0;
      reg_x_r <= '0;
      reg_y_r <= '0;
      reg_w_r <= '0;
      reg_h_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATLAS_W:  atl_w_r <= cfg_pwdata[ATL_W-1:0];
        REG_ATLAS_H:  atl_h_r <= cfg_pwdata[ATL_W-1:0];
        REG_SRC_W:    src_w_r <= cfg_pwdata[SRC_W-1:0];
        REG_SRC_H:    src_h_r <= cfg_pwdata[SRC_W-1:0];
        REG_REGION_X: reg_x_r <= cfg_pwdata[SRC_W-1:0];
        REG_REGION_Y: reg_y_r <= cfg_pwdata[SRC_W-1:0];
        REG_REGION_W: reg_w_r <= cfg_pwdata[SRC_W-1:0];
        REG_REGION_H: reg_h_r <= cfg_pwdata[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // Region in atlas pixels; the reference space is 256 wide, so the floor is a shift.
  assign px0_w = PROD_W'(reg_x_r) * PROD_W'(atl_w_r);
  assign py0_w = PROD_W'(reg_y_r) * PROD_W'(atl_h_r);
  assign pdw_w = PROD_W'(reg_w_r) * PROD_W'(atl_w_r);
  assign pdh_w = PROD_W'(reg_h_r) * PROD_W'(atl_h_r);

  always_ff @(posedge clk) begin
    x0_r     <= px0_w[PROD_W-1:SRC_AW];
    y0_r     <= py0_w[PROD_W-1:SRC_AW];
    dw_r     <= pdw_w[PROD_W-1:SRC_AW];
    dh_r     <= pdh_w[PROD_W-1:SRC_AW];
    sw_r     <= (src_w_r > SRC_W'(SRC_DIM)) ? SRC_W'(SRC_DIM) : src_w_r;
    sh_r     <= (src_h_r > SRC_W'(SRC_DIM)) ? SRC_W'(SRC_DIM) : src_h_r;
    src_ok_r <= (src_w_r != '0) && (src_h_r != '0) && (atl_w_r != '0) &&
                (atl_h_r != '0) && (pdw_w[PROD_W-1:SRC_AW] != '0) &&
                (pdh_w[PROD_W-1:SRC_AW] != '0);
  end

  // The whole pipeline moves whenever the output register can take a word.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // Stage B: region test, offsets into the region, and the load address check.
  always_comb begin
    logic [CRD_W-1:0] px12, py12, offx12, offy12;
    logic             in_x, in_y;
    px12   = CRD_W'(a_px_r);
    py12   = CRD_W'(a_py_r);
    offx12 = px12 - x0_r;
    offy12 = py12 - y0_r;
    in_x   = (ATL_W'(a_px_r) < atl_w_r) && (px12 >= x0_r) && (offx12 < dw_r);
    in_y   = (ATL_W'(a_py_r) < atl_h_r) && (py12 >= y0_r) && (offy12 < dh_r);
    b_ctl_nxt       = a_ctl_r;
    b_ctl_nxt.cov   = a_ctl_r.proc && src_ok_r && in_x && in_y;
    b_ctl_nxt.wr_ok = !a_ctl_r.proc && (a_px_r[POS_W-1:SRC_AW] == '0) &&
                      (a_py_r[POS_W-1:SRC_AW] == '0);
    b_ctl_nxt.waddr = {a_py_r[SRC_AW-1:0], a_px_r[SRC_AW-1:0]};
    b_offx_nxt      = offx12[OFS_W-1:0];
    b_offy_nxt      = offy12[OFS_W-1:0];
  end

  // Stage C forms the dividends; the divider stages then retire two quotient bits each.
  always_comb begin
    logic [REM_W-1:0] rx, ry, dvx, dvy;
    logic [IDX_W-1:0] qx, qy;
    logic [2:0]       bp;
    dctl_nxt[0] = b_ctl_r;
    remx_nxt[0] = REM_W'(b_offx_r) * REM_W'(sw_r);
    remy_nxt[0] = REM_W'(b_offy_r) * REM_W'(sh_r);
    qx_nxt[0]   = '0;
    qy_nxt[0]   = '0;
    for (int s = 0; s < DIV_STG; s++) begin
      rx = remx_r[s];
      ry = remy_r[s];
      qx = qx_r[s];
      qy = qy_r[s];
      for (int j = 0; j < 2; j++) begin
        bp  = 3'(IDX_W - 1 - 2 * s - j);
        dvx = REM_W'(dw_r) << bp;
        dvy = REM_W'(dh_r) << bp;
        if (rx >= dvx) begin
          rx     = rx - dvx;
          qx[bp] = 1'b1;
        end
        if (ry >= dvy) begin
          ry     = ry - dvy;
          qy[bp] = 1'b1;
        end
      end
      dctl_nxt[s+1] = dctl_r[s];
      remx_nxt[s+1] = rx;
      remy_nxt[s+1] = ry;
      qx_nxt[s+1]   = qx;
      qy_nxt[s+1]   = qy;
    end
  end

  // Stage E: source store, written by loads and read by covered pixels.
  assign ram_we    = adv && dctl_r[DIV_STG].vld && dctl_r[DIV_STG].wr_ok;
  assign ram_re    = adv && dctl_r[DIV_STG].vld && dctl_r[DIV_STG].cov;
  assign ram_raddr = {qy_r[DIV_STG], qx_r[DIV_STG]};

  sarb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SRC_DEPTH)
  ) u_src_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dctl_r[DIV_STG].waddr),
    .wdata (dctl_r[DIV_STG].pix),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage F: weighted color sums.
  always_comb begin
    logic [CH_W-1:0] a;
    a = ram_rdata[PIX_W-1 -: CH_W];
    for (int k = 0; k < 3; k++) begin
      f_sum_nxt[k] = SUM_W'(ram_rdata[CH_W*k +: CH_W]) * SUM_W'(a) +
                     SUM_W'(e_ctl_r.pix[CH_W*k +: CH_W]) * SUM_W'(CH_MAX - a);
    end
  end

  // Stage G: blend select into the output register.
  always_comb begin
    logic [CH_W-1:0] a;
    logic [CH_W:0]   asum;
    a    = f_src_r[PIX_W-1 -: CH_W];
    asum = (CH_W+1)'(f_ctl_r.pix[PIX_W-1 -: CH_W]) + (CH_W+1)'(a);
    priority if (!f_ctl_r.cov || a == '0) begin
      out_pix_nxt = f_ctl_r.pix;
    end else if (a == CH_MAX) begin
      out_pix_nxt = {CH_MAX, f_src_r[PIX_W-CH_W-1:0]};
    end else begin
      out_pix_nxt = {asum[CH_W] ? CH_MAX : asum[CH_W-1:0],
                     div255(f_sum_r[2]), div255(f_sum_r[1]), div255(f_sum_r[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r   <= '0;
      b_ctl_r   <= '0;
      e_ctl_r   <= '0;
      f_ctl_r   <= '0;
      out_vld_r <= 1'b0;
      for (int s = 0; s <= DIV_STG; s++) begin
        dctl_r[s] <= '0;
      end
    end else if (adv) begin
      a_ctl_r.vld   <= in_tvalid;
      a_ctl_r.proc  <= in_tuser;
      a_ctl_r.cov   <= 1'b0;
      a_ctl_r.wr_ok <= 1'b0;
      a_ctl_r.waddr <= '0;
      a_ctl_r.pix   <= in_tdata[2*POS_W +: PIX_W];
      b_ctl_r       <= b_ctl_nxt;
      for (int s = 0; s <= DIV_STG; s++) begin
        dctl_r[s] <= dctl_nxt[s];
      end
      e_ctl_r   <= dctl_r[DIV_STG];
      f_ctl_r   <= e_ctl_r;
      out_vld_r <= f_ctl_r.vld && f_ctl_r.proc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px_r   <= in_tdata[POS_W-1:0];
      a_py_r   <= in_tdata[2*POS_W-1:POS_W];
      b_offx_r <= b_offx_nxt;
      b_offy_r <= b_offy_nxt;
      for (int s = 0; s <= DIV_STG; s++) begin
        remx_r[s] <= remx_nxt[s];
        remy_r[s] <= remy_nxt[s];
        qx_r[s]   <= qx_nxt[s];
        qy_r[s]   <= qy_nxt[s];
      end
      for (int k = 0; k < 3; k++) begin
        f_sum_r[k] <= f_sum_nxt[k];
      end
      f_src_r   <= ram_rdata;
      out_pix_r <= out_pix_nxt;
      out_cov_r <= f_ctl_r.cov;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_cov_r;

endmodule

>>> rtl/sarb_ram.sv
`timescale 1ns / 1ps
module sarb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
